// File: rtl/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package bda_pkg;

    localparam int unsigned DIGIT_COUNT = 20;
    localparam int unsigned POS_W       = $clog2(DIGIT_COUNT);
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned MUL_W       = VALUE_W + 4;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CHAR_W      = 6;

    localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(DIGIT_COUNT - 1);
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    // Multiples 0 to 9 of each power of ten, most significant position first
    typedef logic [9:0][MUL_W-1:0]        t_mul_row;
    typedef t_mul_row [DIGIT_COUNT-1:0]   t_mul_tab;

    function automatic t_mul_tab build_mul_tab();
        t_mul_tab           tab;
        logic [MUL_W-1:0]   p;
        p = MUL_W'(1);
        for (int pos = DIGIT_COUNT - 1; pos >= 0; pos--) begin
            for (int k = 0; k < 10; k++) begin
                tab[pos][k] = MUL_W'(p * k);
            end
            p = MUL_W'(p * 10);
        end
        return tab;
    endfunction

    localparam t_mul_tab MUL_TAB = build_mul_tab();

    // Sequencer commands to the datapath
    typedef struct packed {
        logic             load;
        logic             step;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_bda_cmd;

endpackage

// File: rtl/bda_ctrl.sv
// Sequencer: walks the twenty digit positions of one word.
module bda_ctrl
    import bda_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output t_bda_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state           r_state;
    logic [POS_W-1:0] r_pos;

    // Hold state and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_RUN;
                        r_pos   <= '0;
                    end
                end
                S_RUN: begin
                    if (r_pos == LAST_POS) begin
                        r_state <= S_IDLE;
                    end
                    r_pos <= r_pos + POS_W'(1);
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Drive commands from the current state
    assign busy       = (r_state == S_RUN);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.step = (r_state == S_RUN);
    assign o_cmd.pos  = r_pos;
    assign o_cmd.last = (r_pos == LAST_POS);

endmodule

// File: rtl/bda_dpath.sv
// Datapath: remainder register, digit compare and subtract, output word.
module bda_dpath
    import bda_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_bda_cmd            i_cmd,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    output logic [CHAR_W-1:0]   o_digit_char,
    output logic                o_last_digit
);

    logic [VALUE_W-1:0] r_rem;
    logic               r_leading;
    logic               r_valid;
    logic [CHAR_W-1:0]  r_digit_char;
    logic               r_last_digit;

    t_mul_row           row;
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] n_rem;
    logic               emit;

    // Resolve one digit by comparing against all nine multiples at once
    always_comb begin
        row   = MUL_TAB[i_cmd.pos];
        digit = '0;
        for (int k = 1; k < 10; k++) begin
            if ({4'b0, r_rem} >= row[k]) begin
                digit = DIGIT_W'(k);
            end
        end
        n_rem = r_rem - row[digit][VALUE_W-1:0];
        emit  = (digit != '0) || !r_leading || i_cmd.last;
    end

    // Advance remainder and leading-zero flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem     <= i_value;
            r_leading <= 1'b1;
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            if (emit) begin
                r_leading <= 1'b0;
            end
        end
    end

    // Register the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit_char <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
        r_last_digit <= i_cmd.last;
    end

    assign o_valid      = r_valid;
    assign o_digit_char = r_digit_char;
    assign o_last_digit = r_last_digit;

endmodule

// File: rtl/binary_to_decimal_ascii_unit.sv
// Top level: 64-bit binary to decimal ASCII digits, most significant first.
// Each word is walked through the sequencer one decimal position at a time; busy is
// high while it runs and a new word may start once busy drops, so words never overlap.
// Leading zeros give no strobe; the final position is always strobed with o_last_digit.
// Digits are strobed on o_valid for one cycle each; the receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle and clears o_valid.
module binary_to_decimal_ascii_unit
    import bda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last_digit
);

    t_bda_cmd cmd;

    bda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    bda_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

// File: tb/binary_to_decimal_ascii_checker.sv
// Checker for the decimal converter: predicts digit words and compares them.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_checker
    import bda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_valid,
    input  logic [CHAR_W-1:0]  i_digit_char,
    input  logic               i_last_digit,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_values_in,
    output int                 o_digits_out
);

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } t_digit_word;

    t_digit_word expected_digits [$];

    // Weight of a digit position, position 0 being 10^19
    function automatic logic [VALUE_W-1:0] decade_weight(input int pos);
        logic [VALUE_W-1:0] w;
        w = VALUE_W'(1);
        for (int k = 0; k < DIGIT_COUNT - 1 - pos; k++) begin
            w = w * 10;
        end
        return w;
    endfunction

    // Queue the decimal digits of one value, leading zeros dropped
    function automatic void predict_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] remainder;
        logic [VALUE_W-1:0] weight;
        logic [3:0]         count;
        logic               leading;
        t_digit_word        word;
        remainder = value;
        leading   = 1'b1;
        for (int pos = 0; pos < DIGIT_COUNT; pos++) begin
            weight = decade_weight(pos);
            count  = 4'd0;
            while (remainder >= weight && count < 4'd9) begin
                remainder = remainder - weight;
                count     = count + 4'd1;
            end
            if (count != 4'd0 || !leading || pos == DIGIT_COUNT - 1) begin
                leading         = 1'b0;
                word.digit_char = ASCII_ZERO + CHAR_W'(count);
                word.last_digit = (pos == DIGIT_COUNT - 1);
                expected_digits.push_back(word);
            end
        end
    endfunction

    // Compare each strobed digit with the oldest expectation, then take new values
    always @(posedge i_clk) begin
        t_digit_word want;
        if (i_rst_n) begin
            if (i_valid) begin
                o_digits_out = o_digits_out + 1;
                if (expected_digits.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected digit word char=%0d last=%0b",
                                 $realtime, i_digit_char, i_last_digit);
                end else begin
                    want = expected_digits.pop_front();
                    if (want.digit_char !== i_digit_char ||
                        want.last_digit !== i_last_digit) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display(
                                "%0t: digit mismatch: expected char=%0d last=%0b, %s",
                                $realtime, want.digit_char, want.last_digit,
                                $sformatf("got char=%0d last=%0b",
                                          i_digit_char, i_last_digit));
                    end
                end
            end
            if (i_start && !i_busy) begin
                o_values_in = o_values_in + 1;
                predict_digits(i_value);
            end
        end
        o_pending = expected_digits.size();
    end

endmodule

// File: tb/binary_to_decimal_ascii_unit_tb.sv
// Testbench top for the decimal converter: stimulus, pacing phases and verdict.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit_tb;
    import bda_pkg::*;

    localparam int PHASE_WORDS = 112;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [VALUE_W-1:0] DIRECTED_VALUES [20] = '{
        64'd0,
        64'd1,
        64'd9,
        64'd10,
        64'd19,
        64'd99,
        64'd100,
        64'd101,
        64'd1000000007,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'd10000000000000000000,
        64'd9999999999999999999,
        64'd1000000000000000000,
        64'd999999999999999999,
        64'h8000_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'd10000000000000000001,
        64'd1010101010101010101,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555
    };

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               busy;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_digit_char;
    logic               o_last_digit;

    int fail_count;
    int pending;
    int values_in;
    int digits_out;
    int cycle_count = 0;

    binary_to_decimal_ascii_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    binary_to_decimal_ascii_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_valid      (o_valid),
        .i_digit_char (o_digit_char),
        .i_last_digit (o_last_digit),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_values_in  (values_in),
        .o_digits_out (digits_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d digits outstanding",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Random value: full width, a chosen digit count, small, or sparse with zeros
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] span;
        int                 digits;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6, 7: begin
                digits = $urandom_range(1, 19);
                span   = VALUE_W'(1);
                for (int k = 0; k < digits; k++) span = span * 10;
                v = v % span;
            end
            8: v = VALUE_W'($urandom_range(0, 999));
            default: begin
                span = VALUE_W'(1);
                for (int k = $urandom_range(1, 19); k > 0; k--) span = span * 10;
                v = span * VALUE_W'($urandom_range(1, 9)) + VALUE_W'($urandom_range(0, 9));
            end
        endcase
        return v;
    endfunction

    // Offer one word, idling start on a random share of cycles, until taken
    task automatic send_value(input logic [VALUE_W-1:0] value, input int idle_pct);
        logic taken;
        taken = 1'b0;
        while (!taken) begin
            start   <= ($urandom_range(1, 100) > idle_pct);
            i_value <= value;
            @(posedge i_clk);
            taken = start && !busy;
        end
    endtask

    initial begin
        int idle_pct;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words back to back: extremes and internal zeros
        for (int i = 0; i < 20; i++) send_value(DIRECTED_VALUES[i], 0);

        // Random words in four pacing phases; the receiver cannot stall, so the
        // receiver-only phase runs without gaps and the combined one at 15 percent
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       idle_pct = 70;
                3:       idle_pct = 15;
                default: idle_pct = 0;
            endcase
            for (int i = 0; i < PHASE_WORDS; i++) send_value(random_value(), idle_pct);
        end

        // Drain outstanding digits
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Converted %0d values into %0d digit words over four pacing phases,",
                 values_in, digits_out);
        $display("including zero, full scale, powers of ten and internal zeros.");
        if (pending != 0)
            $display("%0d expected digit words never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
